FILE: rtl/bounded_deque_with_search_defines.svh
// assertion macros for the bounded deque block
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
`define BDWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDWS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDWS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/bdws_pkg.sv
package bdws_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        FN_APPEND     = 3'd0,
        FN_PREPEND    = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_CLEAR      = 3'd4,
        FN_FIND_FIRST = 3'd5,
        FN_FIND_LAST  = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SEARCH,
        S_FINISH
    } state_t;

endpackage

FILE: rtl/bdws_ram.sv
module bdws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bounded_deque_with_search.sv
// channel  signals                      direction  payload
// input    in_valid / in_ready          in         func, value
// result   out_valid / out_ready        out        status, found, match_index, count
//
// append, remove last, clear, refused operations and the unused code go straight to the
// finishing state; remove first shifts the stored words down, prepend shifts them up,
// and a search reads the stored words one by one until a match or the end of the deque
// in_ready is high only while idle; a result waits in the output register while the
// next item runs, and that item cannot finish until the register is free
// reset clears the count and the control state, stored words stay undefined
`include "bounded_deque_with_search_defines.svh"

module bounded_deque_with_search #(
    parameter int CAPACITY   = bdws_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = bdws_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               found,
    output logic [5:0]         match_index,
    output logic [6:0]         count
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int VW  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int OCW = (CW > 7) ? CW : 7;
    localparam int OIW = (IW > 6) ? IW : 6;

    bdws_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [IW-1:0]     wa_reg, wa_next;
    logic              pend_reg, pend_next;
    logic              last_reg, last_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    bdws_pkg::status_t rstat_reg, rstat_next;
    logic              rhit_reg, rhit_next;
    logic [IW-1:0]     ridx_reg, ridx_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic              found_reg, found_next;
    logic [5:0]        index_reg, index_next;
    logic [6:0]        ocount_reg, ocount_next;

    logic signed [VW-1:0]  value_ext;
    logic [DATA_WIDTH-1:0] in_word;
    logic [CW-1:0]         ptr_dec, ptr_inc;
    logic [OCW-1:0]        count_wide;
    logic [OIW-1:0]        index_wide;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

    logic                  in_xfer, res_hit, res_ok, in_work;

    bdws_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign value_ext  = VW'(value);
    assign in_word    = value_ext[DATA_WIDTH-1:0];
    assign ptr_dec    = ptr_reg - 1'b1;
    assign ptr_inc    = ptr_reg + 1'b1;
    assign count_wide = OCW'(count_reg);
    assign index_wide = OIW'(ridx_reg);

    assign in_ready    = (state_reg == bdws_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign match_index = index_reg;
    assign count       = ocount_reg;

    assign in_xfer = in_valid & in_ready;
    assign res_hit = out_valid & found;
    assign res_ok  = (status == bdws_pkg::ST_OK);
    assign in_work = (state_reg == bdws_pkg::S_SHIFT_UP) ||
                     (state_reg == bdws_pkg::S_SHIFT_DN) ||
                     (state_reg == bdws_pkg::S_SEARCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdws_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        wa_reg     <= wa_next;
        last_reg   <= last_next;
        word_reg   <= word_next;
        rstat_reg  <= rstat_next;
        rhit_reg   <= rhit_next;
        ridx_reg   <= ridx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        index_reg  <= index_next;
        ocount_reg <= ocount_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        wa_next        = wa_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        word_next      = word_reg;
        rstat_next     = rstat_reg;
        rhit_next      = rhit_reg;
        ridx_next      = ridx_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        status_next    = status_reg;
        found_next     = found_reg;
        index_next     = index_reg;
        ocount_next    = ocount_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = word_reg;
        mem_raddr      = '0;

        case (state_reg)
            bdws_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = in_word;
                    rstat_next = bdws_pkg::ST_OK;
                    rhit_next  = 1'b0;
                    ridx_next  = '0;
                    pend_next  = 1'b0;
                    state_next = bdws_pkg::S_FINISH;
                    case (func)
                        bdws_pkg::FN_APPEND:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                rstat_next = bdws_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IW-1:0];
                                mem_wdata  = in_word;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdws_pkg::FN_PREPEND:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                rstat_next = bdws_pkg::ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                count_next = count_reg + 1'b1;
                                state_next = bdws_pkg::S_SHIFT_UP;
                            end
                        end
                        bdws_pkg::FN_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = bdws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = CW'(1);
                                count_next = count_reg - 1'b1;
                                state_next = bdws_pkg::S_SHIFT_DN;
                            end
                        end
                        bdws_pkg::FN_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = bdws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bdws_pkg::FN_CLEAR:
                        begin
                            count_next = '0;
                        end
                        bdws_pkg::FN_FIND_FIRST:
                        begin
                            ptr_next   = '0;
                            last_next  = 1'b0;
                            state_next = bdws_pkg::S_SEARCH;
                        end
                        bdws_pkg::FN_FIND_LAST:
                        begin
                            ptr_next   = count_reg;
                            last_next  = 1'b1;
                            state_next = bdws_pkg::S_SEARCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // ptr_reg is the destination of the read issued this cycle
            bdws_pkg::S_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg != '0)
                begin
                    mem_raddr = ptr_dec[IW-1:0];
                    wa_next   = ptr_reg[IW-1:0];
                    pend_next = 1'b1;
                    ptr_next  = ptr_dec;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = word_reg;
                    state_next = bdws_pkg::S_FINISH;
                end
            end

            // count_reg already holds the reduced count
            bdws_pkg::S_SHIFT_DN:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg <= count_reg)
                begin
                    mem_raddr = ptr_reg[IW-1:0];
                    wa_next   = ptr_dec[IW-1:0];
                    pend_next = 1'b1;
                    ptr_next  = ptr_inc;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = bdws_pkg::S_FINISH;
                end
            end

            bdws_pkg::S_SEARCH:
            begin
                if (pend_reg && (mem_rdata == word_reg))
                begin
                    rhit_next  = 1'b1;
                    ridx_next  = wa_reg;
                    pend_next  = 1'b0;
                    state_next = bdws_pkg::S_FINISH;
                end
                else if (!last_reg && (ptr_reg < count_reg))
                begin
                    mem_raddr = ptr_reg[IW-1:0];
                    wa_next   = ptr_reg[IW-1:0];
                    pend_next = 1'b1;
                    ptr_next  = ptr_inc;
                end
                else if (last_reg && (ptr_reg != '0))
                begin
                    mem_raddr = ptr_dec[IW-1:0];
                    wa_next   = ptr_dec[IW-1:0];
                    pend_next = 1'b1;
                    ptr_next  = ptr_dec;
                end
                else
                begin
                    rstat_next = bdws_pkg::ST_MISS;
                    pend_next  = 1'b0;
                    state_next = bdws_pkg::S_FINISH;
                end
            end

            bdws_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rstat_reg;
                    found_next     = rhit_reg;
                    index_next     = index_wide[5:0];
                    ocount_next    = count_wide[6:0];
                    state_next     = bdws_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bdws_pkg::S_IDLE;
            end
        endcase
    end

    `BDWS_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(CAPACITY), "count above capacity")
    `BDWS_ASSERT(a_busy_after_transfer, clk, rst_n, in_xfer |=> !in_ready, "ready after transfer")
    `BDWS_ASSERT(a_found_is_ok, clk, rst_n, res_hit |-> res_ok, "found with bad status")
    `BDWS_ASSERT(a_pend_in_work, clk, rst_n, pend_reg |-> in_work, "read pending outside work")

endmodule
